FILE: src/ist_pkg.sv
// ist_pkg: shared types and constants for the integer set table.
// Used by integer_set_table, ist_ram, ist_chk and the testbench. No dependencies.
`timescale 1ns / 1ps

package ist_pkg;

  localparam int WORD_W = 32;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_QUERY  = 2'd2,
    OP_CLEAR  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_PRESENT = 2'd1,
    ST_ABSENT  = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

endpackage

FILE: src/ist_ram.sv
// ist_ram: simple dual-port entry store, one write and one read port.
// Registered read data. Depends on ist_pkg.
`timescale 1ns / 1ps

module ist_ram import ist_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [WORD_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output logic [WORD_W-1:0] rd_data
);

  logic [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: src/integer_set_table.sv
// integer_set_table: set of distinct 32-bit integers kept in insertion order.
// Top level; instantiates ist_ram, depends on ist_pkg.
`timescale 1ns / 1ps

// The table holds up to CAPACITY distinct 32-bit values in the order they
// were added, in one entry RAM with a registered read. Each input transfer
// (opcode, value) gives exactly one result transfer (found, status, count,
// empty_res). Add appends an absent value (refused with status full when the
// table is full), remove deletes a present value and moves every later entry
// down one place, query only reports membership, clear empties the table in
// one step. Timing is set by the single RAM read port: the lookup streams one
// entry per cycle and stops at a hit. A remove scans up to the hit and then
// moves the later entries, so the two passes cover the table once. One item
// is processed at a time: in_stall is high from the cycle after an input
// transfer until the result has been placed in the output register. That
// register holds a result while out_stall is high, and the next input
// transfer is taken meanwhile. The entry RAM needs no clearing after reset;
// only positions below the element count are read. count is the element
// count truncated to 5 bits.
module integer_set_table import ist_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic signed [31:0] value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        found,
  output logic [1:0]  status,
  output logic [4:0]  count,
  output logic        empty_res
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,   // stream entries through the read port, compare to the key
    S_SHIFT,  // remove: copy entry i+1 to i for every later entry
    S_FIN     // hand the result to the output register
  } state_t;

  state_t              state;
  opcode_t             op_q;
  logic [WORD_W-1:0]   val_q;
  logic [CW-1:0]       elem_cnt;
  logic [CW-1:0]       idx;        // next position to read
  logic                rd_valid;   // rd_data holds entry rd_idx
  logic [CW-1:0]       rd_idx;
  logic                res_found;
  status_t             res_status;

  logic [WORD_W-1:0]   rd_data;
  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [WORD_W-1:0]   wr_data;
  logic                hit;
  logic                scan_done;
  logic                shift_done;
  logic [CW-1:0]       rd_idx_m1;
  logic [CW+4:0]       cnt_ext;

  assign in_stall = rst || (state != S_IDLE);

  // A hit is known in the cycle after its read was issued.
  assign hit        = rd_valid && (rd_data == val_q);
  assign scan_done  = hit || ((idx == elem_cnt) && !rd_valid);
  assign shift_done = (idx == elem_cnt) && !rd_valid;
  assign rd_idx_m1  = rd_idx - CW'(1);
  assign cnt_ext    = {5'b0, elem_cnt};

  // Stop issuing reads once the key is found so nothing stale is left in
  // flight when the shift pass starts.
  assign rd_en   = ((state == S_SCAN) && !hit && (idx < elem_cnt)) ||
                   ((state == S_SHIFT) && (idx < elem_cnt));
  assign rd_addr = idx[AW-1:0];

  // Shift writes land at rd_idx - 1, always below the address being read,
  // so the two ports never touch the same entry in one cycle. An append is
  // written in the last scan cycle, before any later read can see it.
  assign wr_en   = ((state == S_SCAN) && scan_done && !hit && (op_q == OP_ADD) &&
                    (elem_cnt < CAP_C)) ||
                   ((state == S_SHIFT) && rd_valid);
  assign wr_addr = (state == S_SHIFT) ? rd_idx_m1[AW-1:0] : elem_cnt[AW-1:0];
  assign wr_data = (state == S_SHIFT) ? rd_data : val_q;

  ist_ram #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      elem_cnt  <= '0;
      rd_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_valid <= rd_en;
      rd_idx   <= idx;

      // S_FIN loads the output register itself
      if (out_valid && !out_stall && (state != S_FIN)) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_q  <= opcode_t'(opcode);
            val_q <= value;
            idx   <= '0;
            if (opcode_t'(opcode) == OP_CLEAR) begin
              elem_cnt   <= '0;
              res_found  <= 1'b0;
              res_status <= ST_DONE;
              state      <= S_FIN;
            end else begin
              state <= S_SCAN;
            end
          end
        end

        S_SCAN: begin
          if (rd_en) begin
            idx <= idx + CW'(1);
          end
          if (scan_done) begin
            res_found <= hit;
            state     <= S_FIN;
            case (op_q)
              OP_ADD: begin
                if (hit) begin
                  res_status <= ST_PRESENT;
                end else if (elem_cnt >= CAP_C) begin
                  res_status <= ST_FULL;
                end else begin
                  res_status <= ST_DONE;
                  elem_cnt   <= elem_cnt + CW'(1);
                end
              end
              OP_REMOVE: begin
                if (hit) begin
                  res_status <= ST_DONE;
                  idx        <= rd_idx + CW'(1);
                  state      <= S_SHIFT;
                end else begin
                  res_status <= ST_ABSENT;
                end
              end
              default: begin
                res_status <= hit ? ST_DONE : ST_ABSENT;
              end
            endcase
          end
        end

        S_SHIFT: begin
          if (rd_en) begin
            idx <= idx + CW'(1);
          end
          if (shift_done) begin
            elem_cnt <= elem_cnt - CW'(1);
            state    <= S_FIN;
          end
        end

        S_FIN: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            found     <= res_found;
            status    <= res_status;
            count     <= cnt_ext[4:0];
            empty_res <= (elem_cnt == '0);
            state     <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: src/ist_chk.sv
// ist_chk: port-level checks for integer_set_table, attached by bind.
// Depends on ist_pkg and the integer_set_table ports.
`timescale 1ns / 1ps

module ist_chk import ist_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       found,
  input logic [1:0] status,
  input logic [4:0] count,
  input logic       empty_res
);

  // one item at a time: busy right after an input transfer
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an item is in work");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable({found, status, count, empty_res}))
    else $error("stalled result changed");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (CAPACITY > 31) || (empty_res == (count == 5'd0)))
    else $error("empty flag disagrees with count");

  a_found_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_DONE) |-> found == (status == ST_PRESENT))
    else $error("found disagrees with status");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_FULL) |-> (CAPACITY > 31) || (count == 5'(CAPACITY)))
    else $error("add refused while not full");

endmodule

bind integer_set_table ist_chk #(.CAPACITY(CAPACITY)) u_ist_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .found     (found),
  .status    (status),
  .count     (count),
  .empty_res (empty_res)
);

FILE: bench/integer_set_table_tb.sv
// Testbench for integer_set_table: directed table, then random add/remove/query/clear traffic.
// Depends on ist_pkg and the integer_set_table RTL; the expected results come from a set model
// kept in this file or are written out by hand in the directed table.
`timescale 1ns / 1ps

module testbench;
  import ist_pkg::*;

  localparam int SET_CAP     = 16;
  localparam int RAND_ITEMS  = 750;
  localparam int PHASE_LEN   = 50;      // items per random phase (pool and idle mode redrawn)
  localparam int HOLD_AT     = 150;     // result index where the receiver holds off for long
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 2 * SET_CAP + 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_REPORTS = 10;

  // One result transfer, in port order.
  typedef struct packed {
    logic       found;
    status_t    status;
    logic [4:0] count;
    logic       empty_res;
  } set_result_t;

  // One row of the directed table. A row with reps > 1 sends value, value+1, ... in turn.
  // Rows with typed set carry their result written out by hand; the rest use the model.
  typedef struct packed {
    opcode_t     op;
    logic [31:0] val;
    logic [4:0]  reps;
    logic        typed;
    set_result_t want;
  } dir_row_t;

  localparam int NDIR = 17;
  localparam dir_row_t DIR_TAB [NDIR] = '{
    // fresh after reset: nothing stored
    '{OP_QUERY,  32'h0000_0000, 5'd1,  1'b1, '{1'b0, ST_ABSENT,  5'd0,  1'b1}},
    '{OP_REMOVE, 32'h0000_0000, 5'd1,  1'b1, '{1'b0, ST_ABSENT,  5'd0,  1'b1}},
    // extremes of the value field
    '{OP_ADD,    32'h8000_0000, 5'd1,  1'b1, '{1'b0, ST_DONE,    5'd1,  1'b0}},
    '{OP_ADD,    32'h7FFF_FFFF, 5'd1,  1'b1, '{1'b0, ST_DONE,    5'd2,  1'b0}},
    '{OP_ADD,    32'h8000_0000, 5'd1,  1'b1, '{1'b1, ST_PRESENT, 5'd2,  1'b0}},
    '{OP_ADD,    32'hFFFF_FFFF, 5'd1,  1'b1, '{1'b0, ST_DONE,    5'd3,  1'b0}},
    '{OP_QUERY,  32'h7FFF_FFFF, 5'd1,  1'b1, '{1'b1, ST_DONE,    5'd3,  1'b0}},
    // remove the head entry: everything behind it moves down
    '{OP_REMOVE, 32'h8000_0000, 5'd1,  1'b1, '{1'b1, ST_DONE,    5'd2,  1'b0}},
    '{OP_QUERY,  32'h8000_0000, 5'd1,  1'b1, '{1'b0, ST_ABSENT,  5'd2,  1'b0}},
    // clear ignores its value; stale RAM contents must not show up afterwards
    '{OP_CLEAR,  32'hAAAA_AAAA, 5'd1,  1'b1, '{1'b0, ST_DONE,    5'd0,  1'b1}},
    '{OP_QUERY,  32'h7FFF_FFFF, 5'd1,  1'b1, '{1'b0, ST_ABSENT,  5'd0,  1'b1}},
    // fill to capacity, then a refused add and an add of a present value while full
    '{OP_ADD,    32'h5555_0000, 5'd16, 1'b0, '0},
    '{OP_ADD,    32'h1234_5678, 5'd1,  1'b1, '{1'b0, ST_FULL,    5'd16, 1'b0}},
    '{OP_ADD,    32'h5555_0000, 5'd1,  1'b1, '{1'b1, ST_PRESENT, 5'd16, 1'b0}},
    // removes from the middle of a full table, then from the tail
    '{OP_REMOVE, 32'h5555_0007, 5'd1,  1'b0, '0},
    '{OP_REMOVE, 32'h5555_000F, 5'd1,  1'b0, '0},
    '{OP_CLEAR,  32'hFFFF_FFFF, 5'd1,  1'b1, '{1'b0, ST_DONE,    5'd0,  1'b1}}
  };

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         opcode = 2'd0;
  logic signed [31:0] value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               found;
  logic [1:0]         status;
  logic [4:0]         count;
  logic               empty_res;

  // Model of the table contents, advanced once per accepted input transfer.
  logic [31:0]  tbl_entry [SET_CAP];
  int           tbl_len = 0;
  set_result_t  expected_results [$];

  int mismatches = 0;
  int results_taken = 0;
  int cycles = 0;
  int send_gap_max = 11;
  int recv_stall_max = 11;

  integer_set_table #(.CAPACITY(SET_CAP)) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .opcode    (opcode),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .found     (found),
    .status    (status),
    .count     (count),
    .empty_res (empty_res)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Run guard: a hang or a lost result ends here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Set model: lookup by exact 32-bit pattern, append on add, shift-down on remove.
  function automatic set_result_t apply_set_op(opcode_t op, logic [31:0] v);
    set_result_t r;
    int pos;
    int i;
    pos = tbl_len;
    for (i = tbl_len - 1; i >= 0; i--) begin
      if (tbl_entry[i] == v) pos = i;
    end
    r.found = 1'b0;
    r.status = ST_DONE;
    if (op != OP_CLEAR) r.found = (pos < tbl_len);
    case (op)
      OP_CLEAR: begin
        tbl_len = 0;
      end
      OP_ADD: begin
        if (r.found) begin
          r.status = ST_PRESENT;
        end else if (tbl_len >= SET_CAP) begin
          r.status = ST_FULL;
        end else begin
          tbl_entry[tbl_len] = v;
          tbl_len++;
        end
      end
      OP_REMOVE: begin
        if (!r.found) begin
          r.status = ST_ABSENT;
        end else begin
          for (i = pos; i + 1 < tbl_len; i++) tbl_entry[i] = tbl_entry[i + 1];
          tbl_len--;
        end
      end
      default: begin
        r.status = r.found ? ST_DONE : ST_ABSENT;
      end
    endcase
    r.count = tbl_len[4:0];
    r.empty_res = (tbl_len == 0);
    return r;
  endfunction

  // Offer one item after an optional idle gap and hold it until the block takes it.
  // in_valid is left high, so back-to-back items never lower and raise it in one step.
  task automatic send_op(opcode_t op, logic [31:0] v, bit typed, set_result_t want);
    int gap;
    set_result_t predicted;
    gap = $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    value <= v;
    do @(posedge clk); while (in_stall);
    predicted = apply_set_op(op, v);
    expected_results.push_back(typed ? want : predicted);
  endtask

  // Receiver: a random stall before each result, quiet stretches with no stall, and one long
  // hold-off so the output register fills and the block pushes back on its input.
  initial begin
    int n;
    while (rst) @(posedge clk);
    forever begin
      if (results_taken % 40 == 0)
        recv_stall_max = ($urandom_range(0, 3) == 0) ? 0 : 11;
      n = (results_taken == HOLD_AT) ? HOLD_CYCLES : $urandom_range(0, recv_stall_max);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
      results_taken++;
    end
  end

  // Result checker: every result transfer is matched against the oldest expectation.
  always @(posedge clk) begin
    set_result_t want;
    set_result_t got;
    if (!rst && out_valid && !out_stall) begin
      got = '{found, status_t'(status), count, empty_res};
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result with none pending: found=%0b status=%0d count=%0d empty=%0b",
                   $realtime, found, status, count, empty_res);
      end else begin
        want = expected_results.pop_front();
        if (got.found !== want.found || got.status !== want.status ||
            got.count !== want.count || got.empty_res !== want.empty_res) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $write("%0t: mismatch exp found=%0b status=%0d count=%0d empty=%0b,",
                   $realtime, want.found, want.status, want.count, want.empty_res);
            $display(" got found=%0b status=%0d count=%0d empty=%0b",
                     found, status, count, empty_res);
          end
        end
      end
    end
  end

  // Stimulus: reset, directed table, random phases, drain.
  initial begin
    logic [31:0] pool [24];
    int pool_n;
    int k;
    int j;
    int pick;
    opcode_t op;
    logic [31:0] v;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (k = 0; k < NDIR; k++) begin
      for (j = 0; j < DIR_TAB[k].reps; j++)
        send_op(DIR_TAB[k].op, DIR_TAB[k].val + j, DIR_TAB[k].typed, DIR_TAB[k].want);
    end

    // Random part: values mostly from a small per-phase pool so adds collide, removes hit and
    // the table reaches full; the rest are arbitrary 32-bit patterns.
    for (k = 0; k < RAND_ITEMS; k++) begin
      if (k % PHASE_LEN == 0) begin
        send_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 11;
        pool_n = $urandom_range(4, 24);
        for (j = 0; j < 24; j++) begin
          case ($urandom_range(0, 3))
            0: pool[j] = $urandom();
            1: pool[j] = $urandom_range(0, 40);
            2: pool[j] = -$urandom_range(1, 40);
            default: pool[j] = $urandom_range(0, 1) ? 32'h8000_0000 + $urandom_range(0, 3)
                                                    : 32'h7FFF_FFFF - $urandom_range(0, 3);
          endcase
        end
      end
      pick = $urandom_range(0, 99);
      if (pick < 45) op = OP_ADD;
      else if (pick < 72) op = OP_REMOVE;
      else if (pick < 97) op = OP_QUERY;
      else op = OP_CLEAR;
      v = ($urandom_range(0, 9) == 0) ? $urandom() : pool[$urandom_range(0, pool_n - 1)];
      send_op(op, v, 1'b0, '0);
    end
    in_valid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/ist_pkg.sv
src/ist_ram.sv
src/integer_set_table.sv
src/ist_chk.sv
bench/integer_set_table_tb.sv
